@@ rtl/core/stst_pkg.sv @@
// ----------------------------------------------------------------------------
// stst_pkg
// Shared types, phase and error codes, and character classes for the
// statement stream tokenizer.
// ----------------------------------------------------------------------------
package stst_pkg;

  // Parse phases
  localparam logic [3:0] PH_BETWEEN = 4'd0;
  localparam logic [3:0] PH_COMMENT = 4'd1;
  localparam logic [3:0] PH_WORD    = 4'd2;
  localparam logic [3:0] PH_PRESTR  = 4'd3;
  localparam logic [3:0] PH_STR     = 4'd4;
  localparam logic [3:0] PH_ESC     = 4'd5;
  localparam logic [3:0] PH_PRENUM  = 4'd6;
  localparam logic [3:0] PH_NUM     = 4'd7;
  localparam logic [3:0] PH_TRAIL   = 4'd8;

  // Error codes
  localparam logic [3:0] ERR_NONE      = 4'd0;
  localparam logic [3:0] ERR_KEYWORD   = 4'd1;
  localparam logic [3:0] ERR_AFTERexit = 4'd2;
  localparam logic [3:0] ERR_WRITES    = 4'd3;
  localparam logic [3:0] ERR_STRING    = 4'd4;
  localparam logic [3:0] ERR_LITFULL   = 4'd5;
  localparam logic [3:0] ERR_NUMBER    = 4'd6;
  localparam logic [3:0] ERR_TRAILER   = 4'd7;
  localparam logic [3:0] ERR_NOEXIT    = 4'd8;
  localparam logic [3:0] ERR_EARLYEND  = 4'd9;

  // Characters
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;

  localparam int WRITE_LEN = 5;
  localparam int EXIT_LEN  = 4;
  localparam int NUM_MAX   = 255;

  // Output field widths
  localparam int LIT_IDX_W = 11;
  localparam int REC_IDX_W = 5;
  localparam int REC_OFF_W = 11;
  localparam int REC_LEN_W = 12;
  localparam int TOTAL_W   = 6;

  // Running parse state of fixed width
  typedef struct packed {
    logic [3:0] phase;
    logic [2:0] letters;
    logic       wr_ok;
    logic       ex_ok;
    logic       exit_seen;
    logic [7:0] num;
    logic       num_over;
    logic [3:0] err;
  } pst_t;

  localparam pst_t PST_RESET = '{
    phase: PH_BETWEEN, letters: 3'd0, wr_ok: 1'b1, ex_ok: 1'b1,
    exit_seen: 1'b0, num: 8'd0, num_over: 1'b0, err: ERR_NONE
  };

  // One result transaction
  typedef struct packed {
    logic                 lit_valid;
    logic [7:0]           lit_byte;
    logic [LIT_IDX_W-1:0] lit_idx;
    logic                 rec_valid;
    logic [REC_IDX_W-1:0] rec_idx;
    logic [REC_OFF_W-1:0] rec_off;
    logic [REC_LEN_W-1:0] rec_len;
    logic                 finished;
    logic                 accepted;
    logic [3:0]           err;
    logic [7:0]           exit_val;
    logic [TOTAL_W-1:0]   total;
  } res_t;

  function automatic logic is_sep(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF || c == CH_SEMI;
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic [7:0] kw_write(input logic [2:0] k);
    logic [7:0] ch;
    case (k)
      3'd0:    ch = 8'h77; // w
      3'd1:    ch = 8'h72; // r
      3'd2:    ch = 8'h69; // i
      3'd3:    ch = 8'h74; // t
      3'd4:    ch = 8'h65; // e
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] kw_exit(input logic [2:0] k);
    logic [7:0] ch;
    case (k)
      3'd0:    ch = 8'h65; // e
      3'd1:    ch = 8'h78; // x
      3'd2:    ch = 8'h69; // i
      3'd3:    ch = 8'h74; // t
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

@@ rtl/core/statement_stream_tokenizer_unit.sv @@
// An accepted source byte's result is loaded into the output register at the next clock edge.
// Throughput: one byte per cycle; a new byte is taken whenever the output register
//   is empty or is being drained in the same cycle.
// Every accepted byte yields exactly one result transaction.
// Reset (rst, synchronous): parser state to "between statements", counters cleared,
//   output register empty. The parser also returns to that state after each last byte.
// ----------------------------------------------------------------------------
// statement_stream_tokenizer_unit
// Byte-stream parser for write "text" / exit N statements. Emits decoded
// literal bytes, write records and an end-of-source summary.
// ----------------------------------------------------------------------------
module statement_stream_tokenizer_unit #(
  parameter int MAX_WRITES       = 32,
  parameter int LITERAL_CAPACITY = 2048
) (
  input  logic        clk,
  input  logic        rst,
  // source byte channel
  input  logic        item_valid,
  output logic        item_ready,
  input  logic [7:0]  src_byte,
  input  logic        last,
  // result channel
  output logic        result_valid,
  input  logic        result_ready,
  output logic        literal_valid,
  output logic [7:0]  literal_byte,
  output logic [10:0] literal_index,
  output logic        record_valid,
  output logic [4:0]  record_index,
  output logic [10:0] record_offset,
  output logic [11:0] record_length,
  output logic        finished,
  output logic        accepted,
  output logic [3:0]  error_code,
  output logic [7:0]  exit_value,
  output logic [5:0]  total_writes
);

  localparam int WW = $clog2(MAX_WRITES + 1);
  localparam int FW = $clog2(LITERAL_CAPACITY + 1);
  localparam int SW = $clog2(LITERAL_CAPACITY);

  // Parser state: phase, keyword match, number and latched error
  stst_pkg::pst_t st;
  stst_pkg::pst_t st_next;
  logic [WW-1:0]  writes;
  logic [WW-1:0]  writes_next;
  logic [FW-1:0]  fill;
  logic [FW-1:0]  fill_next;
  logic [SW-1:0]  start;
  logic [SW-1:0]  start_next;

  // Output register
  stst_pkg::res_t res;
  stst_pkg::res_t res_next;

  logic acc;

  // Take a byte when the output register is empty or drains this cycle,
  // so one byte can enter every cycle while the consumer keeps up.
  assign item_ready = !result_valid || result_ready;
  assign acc        = item_valid && item_ready;

  stst_next #(
    .MAX_WRITES       (MAX_WRITES),
    .LITERAL_CAPACITY (LITERAL_CAPACITY)
  ) u_next (
    .st          (st),
    .writes      (writes),
    .fill        (fill),
    .start       (start),
    .src_byte    (src_byte),
    .last        (last),
    .st_next     (st_next),
    .writes_next (writes_next),
    .fill_next   (fill_next),
    .start_next  (start_next),
    .res         (res_next)
  );

  // Advance parser state only on an accepted transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      st     <= stst_pkg::PST_RESET;
      writes <= '0;
      fill   <= '0;
      start  <= '0;
    end else if (acc) begin
      st     <= st_next;
      writes <= writes_next;
      fill   <= fill_next;
      start  <= start_next;
    end
  end

  // Hold the result until the consumer takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (acc) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (acc) begin
      res <= res_next;
    end
  end

  assign literal_valid = res.lit_valid;
  assign literal_byte  = res.lit_byte;
  assign literal_index = res.lit_idx;
  assign record_valid  = res.rec_valid;
  assign record_index  = res.rec_idx;
  assign record_offset = res.rec_off;
  assign record_length = res.rec_len;
  assign finished      = res.finished;
  assign accepted      = res.accepted;
  assign error_code    = res.err;
  assign exit_value    = res.exit_val;
  assign total_writes  = res.total;

  // A byte yields at most one of a literal and a record.
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(literal_valid && record_valid))
    else $error("literal and record in one transaction");

  // An accepted source carries no error code and is a summary.
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && accepted) |-> (finished && error_code == stst_pkg::ERR_NONE))
    else $error("accepted summary with error");

  // The last byte returns the parser to its reset state.
  assert property (@(posedge clk) disable iff (rst)
    (acc && last) |=> (st == stst_pkg::PST_RESET && writes == '0 && fill == '0))
    else $error("parser not cleared after last byte");

  // The literal fill never passes the store capacity.
  assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(LITERAL_CAPACITY))
    else $error("literal fill beyond capacity");

endmodule

@@ rtl/core/stst_next.sv @@
// ----------------------------------------------------------------------------
// stst_next
// Next-state and result logic for one source byte: phase step with one
// re-dispatch, end-of-source close and summary.
// ----------------------------------------------------------------------------
module stst_next #(
  parameter int MAX_WRITES       = 32,
  parameter int LITERAL_CAPACITY = 2048
) (
  input  stst_pkg::pst_t                          st,
  input  logic [$clog2(MAX_WRITES+1)-1:0]         writes,
  input  logic [$clog2(LITERAL_CAPACITY+1)-1:0]   fill,
  input  logic [$clog2(LITERAL_CAPACITY)-1:0]     start,
  input  logic [7:0]                              src_byte,
  input  logic                                    last,
  output stst_pkg::pst_t                          st_next,
  output logic [$clog2(MAX_WRITES+1)-1:0]         writes_next,
  output logic [$clog2(LITERAL_CAPACITY+1)-1:0]   fill_next,
  output logic [$clog2(LITERAL_CAPACITY)-1:0]     start_next,
  output stst_pkg::res_t                          res
);

  localparam int WW = $clog2(MAX_WRITES + 1);
  localparam int FW = $clog2(LITERAL_CAPACITY + 1);
  localparam int SW = $clog2(LITERAL_CAPACITY);

  stst_pkg::pst_t s;
  logic [WW-1:0]  w;
  logic [FW-1:0]  f;
  logic [SW-1:0]  b;
  logic           again;
  logic           store;
  logic [7:0]     sval;
  logic [FW-1:0]  len;
  logic [11:0]    nval;
  stst_pkg::res_t r;

  always_comb begin
    s     = st;
    w     = writes;
    f     = fill;
    b     = start;
    r     = '0;
    again = 1'b1;
    store = 1'b0;
    sval  = 8'd0;
    len   = fill - FW'(start);
    nval  = 12'(st.num) * 12'd10 + 12'(src_byte - stst_pkg::CH_ZERO);

    for (int pass = 0; pass < 2; pass++) begin
      if (again && s.err == stst_pkg::ERR_NONE) begin
        again = 1'b0;
        case (s.phase)
          stst_pkg::PH_BETWEEN: begin
            if (!stst_pkg::is_sep(src_byte)) begin
              if (src_byte == stst_pkg::CH_HASH) begin
                s.phase = stst_pkg::PH_COMMENT;
              end else if (s.exit_seen) begin
                s.err = stst_pkg::ERR_AFTERexit;
              end else if (stst_pkg::is_letter(src_byte)) begin
                s.wr_ok   = src_byte == stst_pkg::kw_write(3'd0);
                s.ex_ok   = src_byte == stst_pkg::kw_exit(3'd0);
                s.letters = 3'd1;
                s.phase   = stst_pkg::PH_WORD;
              end else begin
                s.err = stst_pkg::ERR_KEYWORD;
              end
            end
          end
          stst_pkg::PH_COMMENT: begin
            if (src_byte == stst_pkg::CH_LF) s.phase = stst_pkg::PH_BETWEEN;
          end
          stst_pkg::PH_WORD: begin
            if (stst_pkg::is_letter(src_byte)) begin
              s.wr_ok = s.wr_ok && s.letters < 3'(stst_pkg::WRITE_LEN)
                        && src_byte == stst_pkg::kw_write(s.letters);
              s.ex_ok = s.ex_ok && s.letters < 3'(stst_pkg::EXIT_LEN)
                        && src_byte == stst_pkg::kw_exit(s.letters);
              if (s.letters != 3'd7) s.letters = s.letters + 3'd1;
            end else begin
              // close the keyword, then look at this byte again
              if (s.wr_ok && s.letters == 3'(stst_pkg::WRITE_LEN)) begin
                if (w >= WW'(MAX_WRITES)) s.err = stst_pkg::ERR_WRITES;
                else s.phase = stst_pkg::PH_PRESTR;
              end else if (s.ex_ok && s.letters == 3'(stst_pkg::EXIT_LEN)) begin
                s.phase = stst_pkg::PH_PRENUM;
              end else begin
                s.err = stst_pkg::ERR_KEYWORD;
              end
              again = 1'b1;
            end
          end
          stst_pkg::PH_PRESTR: begin
            if (!stst_pkg::is_sep(src_byte)) begin
              if (src_byte != stst_pkg::CH_QUOTE) begin
                s.err = stst_pkg::ERR_STRING;
              end else if (f >= FW'(LITERAL_CAPACITY)) begin
                s.err = stst_pkg::ERR_LITFULL;
              end else begin
                b       = SW'(f);
                s.phase = stst_pkg::PH_STR;
              end
            end
          end
          stst_pkg::PH_STR: begin
            if (src_byte == stst_pkg::CH_QUOTE) begin
              if (f == FW'(b)) begin
                s.err = stst_pkg::ERR_STRING;
              end else begin
                r.rec_valid = 1'b1;
                r.rec_idx   = stst_pkg::REC_IDX_W'(w);
                r.rec_off   = stst_pkg::REC_OFF_W'(b);
                r.rec_len   = stst_pkg::REC_LEN_W'(len);
                w           = w + WW'(1);
                s.phase     = stst_pkg::PH_TRAIL;
              end
            end else if (src_byte == stst_pkg::CH_BSL) begin
              s.phase = stst_pkg::PH_ESC;
            end else begin
              store = 1'b1;
              sval  = src_byte;
            end
          end
          stst_pkg::PH_ESC: begin
            store = 1'b1;
            case (src_byte)
              stst_pkg::CH_N:     sval = stst_pkg::CH_LF;
              stst_pkg::CH_R:     sval = stst_pkg::CH_CR;
              stst_pkg::CH_T:     sval = stst_pkg::CH_TAB;
              stst_pkg::CH_BSL:   sval = src_byte;
              stst_pkg::CH_QUOTE: sval = src_byte;
              default: begin
                store = 1'b0;
                s.err = stst_pkg::ERR_STRING;
              end
            endcase
          end
          stst_pkg::PH_PRENUM: begin
            if (!stst_pkg::is_sep(src_byte)) begin
              if (stst_pkg::is_digit(src_byte)) begin
                s.num      = src_byte - stst_pkg::CH_ZERO;
                s.num_over = 1'b0;
                s.phase    = stst_pkg::PH_NUM;
              end else begin
                s.err = stst_pkg::ERR_NUMBER;
              end
            end
          end
          stst_pkg::PH_NUM: begin
            if (stst_pkg::is_digit(src_byte)) begin
              if (nval > 12'(stst_pkg::NUM_MAX)) begin
                s.num_over = 1'b1;
                s.err      = stst_pkg::ERR_NUMBER;
              end else begin
                s.num = nval[7:0];
              end
            end else begin
              s.exit_seen = 1'b1;
              s.phase     = stst_pkg::PH_TRAIL;
              again       = 1'b1;
            end
          end
          stst_pkg::PH_TRAIL: begin
            if (src_byte != stst_pkg::CH_SPACE && src_byte != stst_pkg::CH_TAB) begin
              if (src_byte == stst_pkg::CH_HASH) begin
                s.phase = stst_pkg::PH_COMMENT;
              end else if (src_byte == stst_pkg::CH_SEMI || src_byte == stst_pkg::CH_LF ||
                           src_byte == stst_pkg::CH_CR) begin
                s.phase = stst_pkg::PH_BETWEEN;
              end else begin
                s.err = stst_pkg::ERR_TRAILER;
              end
            end
          end
          default: s.phase = stst_pkg::PH_BETWEEN;
        endcase

        // literal store write, shared by plain and escaped bytes
        if (store) begin
          store = 1'b0;
          if (sval < 8'h20 && sval != stst_pkg::CH_LF && sval != stst_pkg::CH_CR &&
              sval != stst_pkg::CH_TAB) begin
            s.err = stst_pkg::ERR_STRING;
          end else if (f >= FW'(LITERAL_CAPACITY)) begin
            s.err = stst_pkg::ERR_LITFULL;
          end else begin
            r.lit_valid = 1'b1;
            r.lit_byte  = sval;
            r.lit_idx   = stst_pkg::LIT_IDX_W'(f);
            f           = f + FW'(1);
            s.phase     = stst_pkg::PH_STR;
          end
        end
      end
    end

    if (last) begin
      if (s.err == stst_pkg::ERR_NONE) begin
        case (s.phase)
          stst_pkg::PH_WORD: begin
            if (s.wr_ok && s.letters == 3'(stst_pkg::WRITE_LEN)) begin
              s.err = (w >= WW'(MAX_WRITES)) ? stst_pkg::ERR_WRITES : stst_pkg::ERR_EARLYEND;
            end else if (s.ex_ok && s.letters == 3'(stst_pkg::EXIT_LEN)) begin
              s.err = stst_pkg::ERR_EARLYEND;
            end else begin
              s.err = stst_pkg::ERR_KEYWORD;
            end
          end
          stst_pkg::PH_NUM:    s.exit_seen = 1'b1;
          stst_pkg::PH_PRESTR: s.err = stst_pkg::ERR_EARLYEND;
          stst_pkg::PH_STR:    s.err = stst_pkg::ERR_EARLYEND;
          stst_pkg::PH_ESC:    s.err = stst_pkg::ERR_EARLYEND;
          stst_pkg::PH_PRENUM: s.err = stst_pkg::ERR_EARLYEND;
          default: ;
        endcase
        if (s.err == stst_pkg::ERR_NONE && !s.exit_seen) s.err = stst_pkg::ERR_NOEXIT;
      end
      r.finished = 1'b1;
      r.accepted = s.err == stst_pkg::ERR_NONE;
      r.err      = s.err;
      r.exit_val = (s.err == stst_pkg::ERR_NONE) ? s.num : 8'd0;
      r.total    = stst_pkg::TOTAL_W'(w);
      // start over for the next source
      s = stst_pkg::PST_RESET;
      w = '0;
      f = '0;
      b = '0;
    end
  end

  assign st_next     = s;
  assign writes_next = w;
  assign fill_next   = f;
  assign start_next  = b;
  assign res         = r;

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Feeds whole source texts, one byte per transaction, into the statement
// tokenizer and checks every result against a cycle-free parser model kept
// here. A short table of sources with known summaries comes first. Then
// random sources follow: mostly well-formed statement lists with random
// content and some damage, with two long write lists at and just past the
// write limit mixed in.
// ----------------------------------------------------------------------------
module testbench;

  localparam int WRITE_CAP   = 32;
  localparam int LIT_CAP     = 2048;
  localparam int RAND_BYTES  = 1700;
  localparam int STALL_LIMIT = 2000;
  localparam int REPORT_MAX  = 10;
  localparam int DRAIN_WAIT  = 20;
  localparam int ROWS        = 4;

  typedef struct packed {
    logic       acc;
    logic [3:0] code;
    logic [7:0] status;
    logic [5:0] count;
  } summary_t;

  typedef struct packed {
    logic [7:0] data;
    logic       lst;
    logic       pinned;
    summary_t   sum;
  } src_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_ready;
  logic [7:0]  src_byte = 8'd0;
  logic        last = 1'b0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  logic        literal_valid;
  logic [7:0]  literal_byte;
  logic [10:0] literal_index;
  logic        record_valid;
  logic [4:0]  record_index;
  logic [10:0] record_offset;
  logic [11:0] record_length;
  logic        finished;
  logic        accepted;
  logic [3:0]  error_code;
  logic [7:0]  exit_value;
  logic [5:0]  total_writes;

  statement_stream_tokenizer_unit #(
    .MAX_WRITES       (WRITE_CAP),
    .LITERAL_CAPACITY (LIT_CAP)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .src_byte      (src_byte),
    .last          (last),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .literal_valid (literal_valid),
    .literal_byte  (literal_byte),
    .literal_index (literal_index),
    .record_valid  (record_valid),
    .record_index  (record_index),
    .record_offset (record_offset),
    .record_length (record_length),
    .finished      (finished),
    .accepted      (accepted),
    .error_code    (error_code),
    .exit_value    (exit_value),
    .total_writes  (total_writes)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Parser model state
  // --------------------------------------------------------------------------
  logic [3:0] tk_phase;
  logic [2:0] tk_letters;
  logic       wr_match;
  logic       ex_match;
  logic       exit_done;
  logic       num_big;
  logic [3:0] err_held;
  int         wr_total;
  int         lit_fill;
  int         str_base;
  int         num_acc;

  localparam logic [39:0] TXT_WRITE = "write";
  localparam logic [31:0] TXT_EXIT  = "exit";

  function automatic logic [7:0] write_char(input int k);
    return (k < stst_pkg::WRITE_LEN) ? TXT_WRITE[39 - 8*k -: 8] : 8'h00;
  endfunction

  function automatic logic [7:0] exit_char(input int k);
    return (k < stst_pkg::EXIT_LEN) ? TXT_EXIT[31 - 8*k -: 8] : 8'h00;
  endfunction

  function automatic bit gap_char(input logic [7:0] c);
    case (c)
      stst_pkg::CH_SPACE, stst_pkg::CH_TAB, stst_pkg::CH_CR, stst_pkg::CH_LF,
      stst_pkg::CH_SEMI: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit alpha_char(input logic [7:0] c);
    logic [7:0] folded;
    folded = c | 8'h20;
    return folded >= 8'h61 && folded <= 8'h7A;
  endfunction

  function automatic bit digit_char(input logic [7:0] c);
    return c >= stst_pkg::CH_ZERO && c <= stst_pkg::CH_ZERO + 8'd9;
  endfunction

  task automatic clear_parser();
    tk_phase   = stst_pkg::PH_BETWEEN;
    tk_letters = 3'd0;
    wr_match   = 1'b1;
    ex_match   = 1'b1;
    exit_done  = 1'b0;
    num_big    = 1'b0;
    err_held   = stst_pkg::ERR_NONE;
    wr_total   = 0;
    lit_fill   = 0;
    str_base   = 0;
    num_acc    = 0;
  endtask

  // Decide what the word just ended was.
  task automatic finish_word();
    if (wr_match && tk_letters == stst_pkg::WRITE_LEN) begin
      if (wr_total >= WRITE_CAP) err_held = stst_pkg::ERR_WRITES;
      else tk_phase = stst_pkg::PH_PRESTR;
    end else if (ex_match && tk_letters == stst_pkg::EXIT_LEN) begin
      tk_phase = stst_pkg::PH_PRENUM;
    end else begin
      err_held = stst_pkg::ERR_KEYWORD;
    end
  endtask

  task automatic keep_literal(input logic [7:0] v, inout stst_pkg::res_t r);
    if (v < stst_pkg::CH_SPACE && v != stst_pkg::CH_LF && v != stst_pkg::CH_CR &&
        v != stst_pkg::CH_TAB) begin
      err_held = stst_pkg::ERR_STRING;
    end else if (lit_fill >= LIT_CAP) begin
      err_held = stst_pkg::ERR_LITFULL;
    end else begin
      r.lit_valid = 1'b1;
      r.lit_byte  = v;
      r.lit_idx   = lit_fill[10:0];
      lit_fill++;
      tk_phase = stst_pkg::PH_STR;
    end
  endtask

  // Advance the model by one source byte and produce its result.
  task automatic parse_step(input logic [7:0] c, input logic fin, output stst_pkg::res_t r);
    bit again;
    int k;
    int v;
    r = '0;
    again = (err_held == stst_pkg::ERR_NONE);
    while (again && err_held == stst_pkg::ERR_NONE) begin
      again = 1'b0;
      case (tk_phase)
        stst_pkg::PH_BETWEEN: begin
          if (!gap_char(c)) begin
            if (c == stst_pkg::CH_HASH) begin
              tk_phase = stst_pkg::PH_COMMENT;
            end else if (exit_done) begin
              err_held = stst_pkg::ERR_AFTERexit;
            end else if (alpha_char(c)) begin
              wr_match   = (c == write_char(0));
              ex_match   = (c == exit_char(0));
              tk_letters = 3'd1;
              tk_phase   = stst_pkg::PH_WORD;
            end else begin
              err_held = stst_pkg::ERR_KEYWORD;
            end
          end
        end
        stst_pkg::PH_COMMENT: begin
          if (c == stst_pkg::CH_LF) tk_phase = stst_pkg::PH_BETWEEN;
        end
        stst_pkg::PH_WORD: begin
          if (alpha_char(c)) begin
            k = tk_letters;
            wr_match = wr_match && k < stst_pkg::WRITE_LEN && c == write_char(k);
            ex_match = ex_match && k < stst_pkg::EXIT_LEN && c == exit_char(k);
            if (k < 7) tk_letters = tk_letters + 3'd1;
          end else begin
            finish_word();
            again = 1'b1;
          end
        end
        stst_pkg::PH_PRESTR: begin
          if (!gap_char(c)) begin
            if (c != stst_pkg::CH_QUOTE) begin
              err_held = stst_pkg::ERR_STRING;
            end else if (lit_fill >= LIT_CAP) begin
              err_held = stst_pkg::ERR_LITFULL;
            end else begin
              str_base = lit_fill;
              tk_phase = stst_pkg::PH_STR;
            end
          end
        end
        stst_pkg::PH_STR: begin
          if (c == stst_pkg::CH_QUOTE) begin
            if (lit_fill == str_base) begin
              err_held = stst_pkg::ERR_STRING;
            end else begin
              r.rec_valid = 1'b1;
              r.rec_idx   = wr_total[4:0];
              r.rec_off   = str_base[10:0];
              r.rec_len   = stst_pkg::REC_LEN_W'(lit_fill - str_base);
              wr_total++;
              tk_phase = stst_pkg::PH_TRAIL;
            end
          end else if (c == stst_pkg::CH_BSL) begin
            tk_phase = stst_pkg::PH_ESC;
          end else begin
            keep_literal(c, r);
          end
        end
        stst_pkg::PH_ESC: begin
          case (c)
            stst_pkg::CH_N:   keep_literal(stst_pkg::CH_LF, r);
            stst_pkg::CH_R:   keep_literal(stst_pkg::CH_CR, r);
            stst_pkg::CH_T:   keep_literal(stst_pkg::CH_TAB, r);
            stst_pkg::CH_BSL, stst_pkg::CH_QUOTE: keep_literal(c, r);
            default:          err_held = stst_pkg::ERR_STRING;
          endcase
        end
        stst_pkg::PH_PRENUM: begin
          if (!gap_char(c)) begin
            if (digit_char(c)) begin
              num_acc  = c - stst_pkg::CH_ZERO;
              num_big  = 1'b0;
              tk_phase = stst_pkg::PH_NUM;
            end else begin
              err_held = stst_pkg::ERR_NUMBER;
            end
          end
        end
        stst_pkg::PH_NUM: begin
          if (digit_char(c)) begin
            v = num_acc * 10 + (c - stst_pkg::CH_ZERO);
            if (v > stst_pkg::NUM_MAX) begin
              num_big  = 1'b1;
              err_held = stst_pkg::ERR_NUMBER;
            end else begin
              num_acc = v;
            end
          end else begin
            exit_done = 1'b1;
            tk_phase  = stst_pkg::PH_TRAIL;
            again     = 1'b1;
          end
        end
        stst_pkg::PH_TRAIL: begin
          if (c == stst_pkg::CH_HASH) begin
            tk_phase = stst_pkg::PH_COMMENT;
          end else if (c == stst_pkg::CH_SEMI || c == stst_pkg::CH_LF ||
                       c == stst_pkg::CH_CR) begin
            tk_phase = stst_pkg::PH_BETWEEN;
          end else if (c != stst_pkg::CH_SPACE && c != stst_pkg::CH_TAB) begin
            err_held = stst_pkg::ERR_TRAILER;
          end
        end
        default: tk_phase = stst_pkg::PH_BETWEEN;
      endcase
    end
    if (fin) begin
      // Close the source: an open word still has to be judged, an open
      // number completes the exit, any other open statement ends too early.
      if (err_held == stst_pkg::ERR_NONE) begin
        if (tk_phase == stst_pkg::PH_WORD) begin
          finish_word();
          if (err_held == stst_pkg::ERR_NONE) err_held = stst_pkg::ERR_EARLYEND;
        end else if (tk_phase == stst_pkg::PH_NUM) begin
          exit_done = 1'b1;
        end else if (tk_phase == stst_pkg::PH_PRESTR || tk_phase == stst_pkg::PH_STR ||
                     tk_phase == stst_pkg::PH_ESC || tk_phase == stst_pkg::PH_PRENUM) begin
          err_held = stst_pkg::ERR_EARLYEND;
        end
        if (err_held == stst_pkg::ERR_NONE && !exit_done) err_held = stst_pkg::ERR_NOEXIT;
      end
      r.finished = 1'b1;
      r.accepted = (err_held == stst_pkg::ERR_NONE);
      r.err      = err_held;
      r.exit_val = (err_held == stst_pkg::ERR_NONE) ? num_acc[7:0] : 8'd0;
      r.total    = wr_total[5:0];
      clear_parser();
    end
  endtask

  // --------------------------------------------------------------------------
  // Source text builder
  // --------------------------------------------------------------------------
  logic [7:0]     text_q [$];
  src_item_t      source_q [$];
  stst_pkg::res_t tokens_due [$];

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  task automatic put_gap(input int n);
    repeat (n) begin
      case ($urandom_range(0, 4))
        0:       text_q.push_back(stst_pkg::CH_SPACE);
        1:       text_q.push_back(stst_pkg::CH_TAB);
        2:       text_q.push_back(stst_pkg::CH_CR);
        3:       text_q.push_back(stst_pkg::CH_LF);
        default: text_q.push_back(stst_pkg::CH_SEMI);
      endcase
    end
  endtask

  task automatic put_comment(input bit close);
    logic [7:0] b;
    text_q.push_back(stst_pkg::CH_HASH);
    repeat ($urandom_range(0, 5)) begin
      do b = 8'($urandom_range(0, 255)); while (b == stst_pkg::CH_LF);
      text_q.push_back(b);
    end
    if (close) text_q.push_back(stst_pkg::CH_LF);
  endtask

  // Emit write "..." whose text decodes to len bytes, all of them legal.
  task automatic put_write(input int len);
    int         r;
    logic [7:0] b;
    put_text("write");
    put_gap($urandom_range(0, 1));
    text_q.push_back(stst_pkg::CH_QUOTE);
    repeat (len) begin
      r = $urandom_range(0, 99);
      if (r < 12) begin
        text_q.push_back(stst_pkg::CH_BSL);
        case ($urandom_range(0, 4))
          0:       text_q.push_back(stst_pkg::CH_N);
          1:       text_q.push_back(stst_pkg::CH_R);
          2:       text_q.push_back(stst_pkg::CH_T);
          3:       text_q.push_back(stst_pkg::CH_BSL);
          default: text_q.push_back(stst_pkg::CH_QUOTE);
        endcase
      end else if (r < 20) begin
        case ($urandom_range(0, 2))
          0:       text_q.push_back(stst_pkg::CH_LF);
          1:       text_q.push_back(stst_pkg::CH_CR);
          default: text_q.push_back(stst_pkg::CH_TAB);
        endcase
      end else if (r < 35) begin
        text_q.push_back(8'($urandom_range(8'h80, 8'hFF)));
      end else if (r < 37) begin
        text_q.push_back(8'h7F);
      end else begin
        do b = 8'($urandom_range(8'h20, 8'h7E));
        while (b == stst_pkg::CH_QUOTE || b == stst_pkg::CH_BSL);
        text_q.push_back(b);
      end
    end
    text_q.push_back(stst_pkg::CH_QUOTE);
  endtask

  task automatic put_exit();
    put_text("exit");
    put_gap($urandom_range(0, 1));
    if ($urandom_range(0, 9) == 0) text_q.push_back(stst_pkg::CH_ZERO);
    if ($urandom_range(0, 99) < 6) put_text($sformatf("%0d", $urandom_range(256, 999)));
    else put_text($sformatf("%0d", $urandom_range(0, 255)));
  endtask

  // Close a statement; at the end of the source the terminator may be left out.
  task automatic put_trailer(input bit at_end);
    int r;
    repeat ($urandom_range(0, 2)) begin
      text_q.push_back($urandom_range(0, 1) ? stst_pkg::CH_SPACE : stst_pkg::CH_TAB);
    end
    r = $urandom_range(0, 9);
    if (!(at_end && r < 3)) begin
      case (r % 4)
        0:       text_q.push_back(stst_pkg::CH_SEMI);
        1:       text_q.push_back(stst_pkg::CH_LF);
        2:       text_q.push_back(stst_pkg::CH_CR);
        default: put_comment(!at_end || $urandom_range(0, 1));
      endcase
    end
  endtask

  task automatic put_junk_word();
    case ($urandom_range(0, 3))
      0:       put_text("Write");
      1:       put_text("writ");
      2:       put_text("exits");
      default: begin
        repeat ($urandom_range(1, 7)) text_q.push_back(8'(8'h61 + $urandom_range(0, 25)));
      end
    endcase
  endtask

  // Build one random source: mostly well-formed, sometimes damaged.
  task automatic make_source();
    int r;
    int keep;
    int idx;
    text_q.delete();
    if ($urandom_range(0, 99) < 3) begin
      repeat ($urandom_range(1, 6)) text_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      if ($urandom_range(0, 3) == 0) put_gap($urandom_range(1, 3));
      if ($urandom_range(0, 5) == 0) put_comment(1'b1);
      repeat ($urandom_range(0, 4)) begin
        if ($urandom_range(0, 99) < 4) begin
          put_junk_word();
          put_gap(1);
        end else begin
          put_write(($urandom_range(0, 99) < 3) ? 0 : $urandom_range(1, 10));
          put_trailer(1'b0);
        end
      end
      if ($urandom_range(0, 99) < 90) begin
        put_exit();
        if ($urandom_range(0, 99) < 5) begin
          // statement after exit
          put_trailer(1'b0);
          if ($urandom_range(0, 1)) put_write($urandom_range(1, 4));
          else put_exit();
        end
        put_trailer(1'b1);
      end
      if (text_q.size() == 0) put_gap(1);
      r = $urandom_range(0, 99);
      if (r < 18) begin
        idx = $urandom_range(0, text_q.size() - 1);
        text_q[idx] = 8'($urandom_range(0, 255));
      end else if (r < 26) begin
        keep = $urandom_range(1, text_q.size());
        while (text_q.size() > keep) void'(text_q.pop_back());
      end
    end
  endtask

  // Long write lists: the full count of writes, or one more.
  task automatic make_write_list(input int n);
    text_q.delete();
    repeat (n) begin
      put_write($urandom_range(1, 3));
      put_trailer(1'b0);
    end
    put_exit();
    put_trailer(1'b1);
  endtask

  task automatic queue_text(input bit pin, input summary_t s);
    src_item_t it;
    for (int i = 0; i < text_q.size(); i++) begin
      it.data   = text_q[i];
      it.lst    = (i == text_q.size() - 1);
      it.pinned = pin && it.lst;
      it.sum    = s;
      source_q.push_back(it);
    end
  endtask

  // --------------------------------------------------------------------------
  // Source side: present bytes, run the model on each accepted transaction
  // --------------------------------------------------------------------------
  int        bytes_taken = 0;
  int        results_seen = 0;
  int        mismatches = 0;
  int        lit_seen = 0;
  int        rec_seen = 0;
  int        src_done = 0;
  int        src_ok = 0;
  int        quiet = 0;
  logic [15:0] codes_seen = '0;
  src_item_t cur_item = '0;

  // Sit out with a chance of 14 in 100, except in one calm stretch.
  function automatic bit sit_out();
    if (bytes_taken >= 700 && bytes_taken < 1100) return 1'b0;
    return $urandom_range(0, 99) < 14;
  endfunction

  always @(posedge clk) begin : feed
    stst_pkg::res_t want;
    src_item_t      nxt;
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && item_ready) begin
        parse_step(src_byte, last, want);
        if (cur_item.pinned) begin
          want.finished = 1'b1;
          want.accepted = cur_item.sum.acc;
          want.err      = cur_item.sum.code;
          want.exit_val = cur_item.sum.status;
          want.total    = cur_item.sum.count;
        end
        tokens_due.push_back(want);
        bytes_taken++;
      end
      if (!item_valid || item_ready) begin
        if (source_q.size() > 0 && !sit_out()) begin
          nxt = source_q.pop_front();
          item_valid <= 1'b1;
          src_byte   <= nxt.data;
          last       <= nxt.lst;
          cur_item   <= nxt;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : drain
    if (rst) result_ready <= 1'b0;
    else result_ready <= !sit_out();
  end

  function automatic string show(input stst_pkg::res_t r);
    return $sformatf("lit %b/%02h/%0d rec %b/%0d/%0d/%0d fin %b acc %b err %0d exit %0d tot %0d",
                     r.lit_valid, r.lit_byte, r.lit_idx, r.rec_valid, r.rec_idx, r.rec_off,
                     r.rec_len, r.finished, r.accepted, r.err, r.exit_val, r.total);
  endfunction

  // --------------------------------------------------------------------------
  // Result side: compare each transaction with the oldest expectation
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check
    stst_pkg::res_t seen;
    stst_pkg::res_t want;
    if (!rst && result_valid && result_ready) begin
      seen = {literal_valid, literal_byte, literal_index, record_valid, record_index,
              record_offset, record_length, finished, accepted, error_code, exit_value,
              total_writes};
      results_seen++;
      if (tokens_due.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) $display("unexpected result: %s", show(seen));
      end else begin
        want = tokens_due.pop_front();
        if (seen !== want) begin
          mismatches++;
          if (mismatches <= REPORT_MAX) begin
            $display("mismatch at result %0d", results_seen);
            $display("  expected %s", show(want));
            $display("  actual   %s", show(seen));
          end
        end
        if (want.lit_valid) lit_seen++;
        if (want.rec_valid) rec_seen++;
        if (want.finished) begin
          src_done++;
          if (want.accepted) src_ok++;
          codes_seen[want.err] = 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      quiet <= 0;
    end else if (quiet >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
      $display("testbench: done, errors");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  string    row_text [ROWS];
  summary_t row_sum  [ROWS];

  initial begin : main
    bit lists_done;
    clear_parser();

    // Sources whose summaries can be read off directly.
    row_text[0] = "\377";                  // top byte where a word must start
    row_sum[0]  = '{1'b0, stst_pkg::ERR_KEYWORD, 8'd0, 6'd0};
    row_text[1] = "#";                     // comment only, no exit
    row_sum[1]  = '{1'b0, stst_pkg::ERR_NOEXIT, 8'd0, 6'd0};
    row_text[2] = "exit 255";              // largest exit status, ends in the number
    row_sum[2]  = '{1'b1, stst_pkg::ERR_NONE, 8'd255, 6'd0};
    row_text[3] = "write\"\\\"\";exit 0";  // escaped quote, no gap before the string
    row_sum[3]  = '{1'b1, stst_pkg::ERR_NONE, 8'd0, 6'd1};
    for (int i = 0; i < ROWS; i++) begin
      text_q.delete();
      put_text(row_text[i]);
      queue_text(1'b1, row_sum[i]);
    end

    // Random sources up to the byte budget, with the write lists inside it.
    lists_done = 1'b0;
    while (source_q.size() < RAND_BYTES) begin
      make_source();
      queue_text(1'b0, '0);
      if (!lists_done && source_q.size() > RAND_BYTES / 4) begin
        make_write_list(WRITE_CAP);
        queue_text(1'b0, '0);
        make_write_list(WRITE_CAP + 1);
        queue_text(1'b0, '0);
        lists_done = 1'b1;
      end
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Sample on the falling edge so every rising-edge update has settled.
    @(negedge clk);
    while (source_q.size() > 0 || item_valid) @(negedge clk);
    while (tokens_due.size() > 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);

    $display("run: %0d source texts, %0d bytes, %0d literal bytes, %0d write records",
             src_done, bytes_taken, lit_seen, rec_seen);
    $display("run: %0d texts parsed clean, summary codes seen %b", src_ok, codes_seen[9:0]);
    if (mismatches == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
